// File: src/lmph_pkg.sv
`default_nettype none

package lmph_pkg;

  // Default fixed-point format: Q7.8 dB
  localparam int DefaultFracBits = 8;

  // Configuration register map
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RELEASE_COEFF    = 8'd0,
    CFG_PEAK_DECAY_COEFF = 8'd1,
    CFG_HOLD_TICKS       = 8'd2,
    CFG_REDRAW_THRESHOLD = 8'd3
  } cfg_reg_e;

  // Field widths
  localparam int LevelW  = 16;
  localparam int CoeffW  = 16;
  localparam int HoldW   = 8;
  localparam int ThreshW = 11;

  // Register reset values
  localparam logic [CoeffW-1:0]  ReleaseCoeffRst   = 16'd9830;
  localparam logic [CoeffW-1:0]  PeakDecayCoeffRst = 16'd1966;
  localparam logic [HoldW-1:0]   HoldTicksRst      = 8'd30;
  localparam logic [ThreshW-1:0] RedrawThreshRst   = 11'd13;

  // Meter scale limits in whole dB
  localparam int FloorDb = -80;
  localparam int CeilDb  = 6;

endpackage

`default_nettype wire

// File: src/level_meter_peak_hold.sv
`default_nettype none

// Level meter ballistics with peak hold. Each accepted transaction on the
// level channel is one meter tick: the signed dB level (FracBits fraction
// bits) is clamped to -80..+6 dB, the shown level jumps up to it or releases
// towards it by release_coeff/65536 of the gap, and the peak jumps to any
// higher level, holds for hold_ticks ticks and then decays towards -80 dB by
// peak_decay_coeff/65536 of the gap (products floor-shifted by 16). redraw is
// raised when the clamped input or the new peak has moved more than
// redraw_threshold from the last drawn values, which are then refreshed.
// Throughput is one transaction per clock while the result register is not
// stalled. The input register takes the level at the accepting edge and the
// result register is loaded from it once that register is free or draining;
// out_valid_o rises with that load. The state update, one multiply-add each
// for the level and the peak, is combinational, so each tick sees the
// previous tick's state.
// A stalled result register holds and backs up into the input register, so
// up to two transactions are in flight. Config writes are always accepted
// (cfg_ready_o is tied high); unknown indexes are dropped. Write config only
// while no transaction is in flight.

module level_meter_peak_hold #(
  parameter int FracBits = lmph_pkg::DefaultFracBits
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // config write channel
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [lmph_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [lmph_pkg::CfgDataW-1:0]     cfg_data_i,
  // level in
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  signed [lmph_pkg::LevelW-1:0] level_in_i,
  // meter out
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic signed [lmph_pkg::LevelW-1:0] shown_level_o,
  output logic signed [lmph_pkg::LevelW-1:0] peak_level_o,
  output logic                              redraw_o
);

  // State width: the -80 dB floor needs FracBits+8 signed bits; never
  // narrower than the input so the clamp sees every input code.
  localparam int StateW = (FracBits + 8 > lmph_pkg::LevelW) ? FracBits + 8
                                                            : lmph_pkg::LevelW;
  localparam int GapW   = StateW + 1;
  localparam int ProdW  = GapW + lmph_pkg::CoeffW + 1;

  localparam logic signed [StateW-1:0] Floor =
    StateW'(lmph_pkg::FloorDb * (2 ** FracBits));
  localparam logic signed [StateW-1:0] Ceil =
    StateW'(lmph_pkg::CeilDb * (2 ** FracBits));

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [lmph_pkg::CoeffW-1:0]  release_q, peak_decay_q;
  logic [lmph_pkg::HoldW-1:0]   hold_ticks_q;
  logic [lmph_pkg::ThreshW-1:0] thresh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_q    <= lmph_pkg::ReleaseCoeffRst;
      peak_decay_q <= lmph_pkg::PeakDecayCoeffRst;
      hold_ticks_q <= lmph_pkg::HoldTicksRst;
      thresh_q     <= lmph_pkg::RedrawThreshRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lmph_pkg::CFG_RELEASE_COEFF:    release_q    <= cfg_data_i;
        lmph_pkg::CFG_PEAK_DECAY_COEFF: peak_decay_q <= cfg_data_i;
        lmph_pkg::CFG_HOLD_TICKS:       hold_ticks_q <= cfg_data_i[lmph_pkg::HoldW-1:0];
        lmph_pkg::CFG_REDRAW_THRESHOLD: thresh_q     <= cfg_data_i[lmph_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register and pipeline control
  // ---------------------------------------------------------------------
  logic                              in_valid_q;
  logic signed [lmph_pkg::LevelW-1:0] in_level_q;
  logic                              out_valid_q;
  logic                              advance;

  // result register free or draining this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_level_q <= level_in_i;
    end
  end

  // ---------------------------------------------------------------------
  // Tick update
  // ---------------------------------------------------------------------
  logic signed [StateW-1:0] level_q, peak_q, drawn_level_q, drawn_peak_q;
  logic [lmph_pkg::HoldW-1:0] hold_q;

  logic signed [StateW-1:0] lvl_ext, lvl;
  logic signed [GapW-1:0]   level_gap, peak_gap;
  logic signed [ProdW-1:0]  rel_prod, dec_prod;
  logic signed [StateW-1:0] level_d, peak_d;
  logic [lmph_pkg::HoldW-1:0] hold_d;
  logic signed [GapW-1:0]   lvl_diff, peak_diff;
  logic [GapW-1:0]          lvl_dist, peak_dist, thresh_ext;
  logic                     redraw_d;

  // clamp to -80..+6 dB
  always_comb begin
    lvl_ext = StateW'(in_level_q);
    if (lvl_ext < Floor) begin
      lvl = Floor;
    end else if (lvl_ext > Ceil) begin
      lvl = Ceil;
    end else begin
      lvl = lvl_ext;
    end
  end

  // gap * coeff, then arithmetic shift by 16 (floor)
  assign level_gap = GapW'(lvl) - GapW'(level_q);
  assign peak_gap  = GapW'(Floor) - GapW'(peak_q);
  assign rel_prod  = ProdW'(level_gap) * ProdW'($signed({1'b0, release_q}));
  assign dec_prod  = ProdW'(peak_gap) * ProdW'($signed({1'b0, peak_decay_q}));

  always_comb begin
    // attack is instant, release closes part of the gap
    if (lvl > level_q) begin
      level_d = lvl;
    end else begin
      level_d = level_q + StateW'(rel_prod >>> lmph_pkg::CoeffW);
    end

    // peak: capture, hold, then decay to floor
    hold_d = hold_q;
    peak_d = peak_q;
    if (lvl > peak_q) begin
      peak_d = lvl;
      hold_d = hold_ticks_q;
    end else if (hold_q != '0) begin
      hold_d = hold_q - lmph_pkg::HoldW'(1);
    end else begin
      peak_d = peak_q + StateW'(dec_prod >>> lmph_pkg::CoeffW);
    end

    // redraw: clamped input vs drawn level, new peak vs drawn peak
    lvl_diff   = GapW'(lvl) - GapW'(drawn_level_q);
    peak_diff  = GapW'(peak_d) - GapW'(drawn_peak_q);
    lvl_dist   = lvl_diff[GapW-1] ? $unsigned(-lvl_diff) : $unsigned(lvl_diff);
    peak_dist  = peak_diff[GapW-1] ? $unsigned(-peak_diff) : $unsigned(peak_diff);
    thresh_ext = GapW'(thresh_q);
    redraw_d   = (lvl_dist > thresh_ext) || (peak_dist > thresh_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= Floor;
      peak_q        <= Floor;
      hold_q        <= '0;
      drawn_level_q <= Floor;
      drawn_peak_q  <= Floor;
    end else if (advance && in_valid_q) begin
      level_q <= level_d;
      peak_q  <= peak_d;
      hold_q  <= hold_d;
      if (redraw_d) begin
        drawn_level_q <= level_d;
        drawn_peak_q  <= peak_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic signed [lmph_pkg::LevelW-1:0] shown_q, peak_out_q;
  logic                              redraw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      shown_q    <= level_d[lmph_pkg::LevelW-1:0];
      peak_out_q <= peak_d[lmph_pkg::LevelW-1:0];
      redraw_q   <= redraw_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign shown_level_o = shown_q;
  assign peak_level_o  = peak_out_q;
  assign redraw_o      = redraw_q;

endmodule

`default_nettype wire

// File: src/lmph_sva.sv
`default_nettype none

module lmph_sva #(
  parameter int FracBits = lmph_pkg::DefaultFracBits
) (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               in_valid_i,
  input wire                               in_ready_o,
  input wire                               out_valid_o,
  input wire                               out_ready_i,
  input wire  signed [lmph_pkg::LevelW-1:0] shown_level_o,
  input wire  signed [lmph_pkg::LevelW-1:0] peak_level_o,
  input wire                               redraw_o
);

  localparam int FloorVal = lmph_pkg::FloorDb * (2 ** FracBits);
  localparam int CeilVal  = lmph_pkg::CeilDb * (2 ** FracBits);
  localparam bit InRange  = (FracBits <= 8);

  // result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(shown_level_o) && $stable(peak_level_o) && $stable(redraw_o))
    else $error("stalled result changed");

  // an empty output side never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // a transaction into an idle output side appears after the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("result missing after accepted level");

  // displayed values stay on the meter scale (checked for FracBits up to 8)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && InRange |->
      (int'(shown_level_o) >= FloorVal) && (int'(shown_level_o) <= CeilVal) &&
      (int'(peak_level_o) >= FloorVal) && (int'(peak_level_o) <= CeilVal))
    else $error("meter value off scale");

endmodule

bind level_meter_peak_hold lmph_sva #(.FracBits(FracBits)) u_lmph_sva (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .shown_level_o(shown_level_o),
  .peak_level_o (peak_level_o),
  .redraw_o     (redraw_o)
);

`default_nettype wire
